### design/teq_pkg.sv
// shared types and constants for the timestamp ordered event queue
// no dependencies; imported by teq_ram, teq_ctrl, the top level and the testbench

package teq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int TIME_W              = 32;
   localparam int PAYLOAD_W           = 32;

   // operation codes carried in req_tuser
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic [TIME_W-1:0]    time_stamp;
   } entry_type;

   typedef struct packed {
      logic      op;
      entry_type entry;
   } item_type;

   typedef struct packed {
      logic                 popped_valid;
      logic [TIME_W-1:0]    popped_time;
      logic [PAYLOAD_W-1:0] popped_payload;
      logic                 dropped;
      logic                 queue_empty;
   } result_type;

endpackage

### design/teq_ram.sv
// event store: one write port, one read port with registered read data
// depends on teq_pkg for entry_type

module teq_ram import teq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int ADDR_W      = $clog2(QUEUE_DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data_ff
);

   entry_type mem [QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

### design/teq_ctrl.sv
// sequencer for the event queue: circular sorted buffer, tail-first insertion
// with one shared timestamp comparator; depends on teq_pkg

module teq_ctrl import teq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int ADDR_W      = $clog2(QUEUE_DEPTH),
   parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  item_type          req_item,
   output logic              req_ready,
   input  logic              out_free,
   output logic              res_push,
   output result_type        res_ff,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output entry_type         wr_data,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  entry_type         rd_data_ff
);

   localparam int SUM_W = CNT_W + 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);
   localparam logic [SUM_W-1:0]  DEPTH_S   = SUM_W'(QUEUE_DEPTH);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_INS  = 5'b00010,
      S_INSW = 5'b00100,
      S_POPW = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   item_type          item_ff, item_in;
   result_type        res_in;

   logic [SUM_W-1:0]  tail_sum;
   logic [SUM_W-1:0]  tail_wrap;
   logic [ADDR_W-1:0] tail;
   logic [ADDR_W-1:0] pos_prev;
   logic [ADDR_W-1:0] head_next;
   logic              new_before;

   // wrap helpers for the circular buffer
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_wrap = (tail_sum >= DEPTH_S) ? (tail_sum - DEPTH_S) : tail_sum;
   assign tail      = tail_wrap[ADDR_W-1:0];
   assign pos_prev  = (pos_ff == '0) ? LAST_ADDR : (pos_ff - ADDR_W'(1));
   assign head_next = (head_ff == LAST_ADDR) ? '0 : (head_ff + ADDR_W'(1));

   // the shared comparator: new event goes ahead of a strictly later one
   assign new_before = item_ff.entry.time_stamp < rd_data_ff.time_stamp;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      rem_in   = rem_ff;
      item_in  = item_ff;
      res_in   = res_ff;
      res_push = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = pos_ff;
      wr_data  = item_ff.entry;
      rd_en    = 1'b0;
      rd_addr  = pos_prev;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in = req_item;
               res_in  = '0;
               if (req_item.op == OP_POP) begin
                  if (count_ff == '0) begin
                     res_in.queue_empty = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     state_in = S_POPW;
                  end
               end else if (count_ff == FULL_CNT) begin
                  res_in.dropped = 1'b1;
                  state_in = S_DONE;
               end else begin
                  pos_in   = tail;
                  rem_in   = count_ff;
                  state_in = S_INS;
               end
            end
         end
         S_INS: begin
            if (rem_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_INSW;
            end
         end
         S_INSW: begin
            wr_en = 1'b1;
            if (new_before) begin
               wr_data  = rd_data_ff;
               pos_in   = pos_prev;
               rem_in   = rem_ff - CNT_W'(1);
               state_in = S_INS;
            end else begin
               count_in = count_ff + CNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_POPW: begin
            res_in.popped_valid   = 1'b1;
            res_in.popped_time    = rd_data_ff.time_stamp;
            res_in.popped_payload = rd_data_ff.payload;
            res_in.queue_empty    = (count_ff == CNT_W'(1));
            head_in  = head_next;
            count_in = count_ff - CNT_W'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               res_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      rem_ff  <= rem_in;
      item_ff <= item_in;
      res_ff  <= res_in;
   end

endmodule

### design/timestamp_ordered_event_queue_top.sv
// top level of the timestamp ordered event queue: stream ports, output register
// depends on teq_pkg, teq_ram and teq_ctrl

// Holds up to QUEUE_DEPTH events (32-bit timestamp, 32-bit payload) in a
// circular buffer kept in ascending timestamp order, ties in arrival order.
// Each request transfer gives exactly one response transfer. A pop reads the
// head entry, takes it into the result in S_POPW and passes the result to the
// response register from S_DONE. An insert walks from the tail toward the head
// using one memory read port and one 32-bit comparator, shifting each stored
// event that is later than the new one a place toward the tail and then
// writing the new event into the freed slot; it stops at the first stored
// event with an equal or smaller timestamp or at the head. An insert into a
// full queue or a pop from an empty one goes straight to S_DONE. A finished
// item waits in S_DONE until the response register is free. The request side
// is busy while an item is in flight; a finished response waits in its own
// register, so the next request is taken while the response is not yet
// picked up. Memory contents need no clearing after reset.

module timestamp_ordered_event_queue_top import teq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] event_time, [63:32] event_payload
   input  logic [0:0]  req_tuser,   // [0] operation
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] popped_time, [63:32] popped_payload
   output logic [2:0]  rsp_tuser    // [0] popped_valid, [1] dropped, [2] queue_empty
);

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   item_type          req_item;
   result_type        res;
   logic              res_push;
   logic              out_free;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   entry_type         rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_res_ff, rsp_res_in;

   // unpack the request transfer
   assign req_item.op               = req_tuser[0];
   assign req_item.entry.time_stamp = req_tdata[31:0];
   assign req_item.entry.payload    = req_tdata[63:32];

   // response register is free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   teq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ADDR_W      (ADDR_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_item   (req_item),
      .req_ready  (req_tready),
      .out_free   (out_free),
      .res_push   (res_push),
      .res_ff     (res),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   teq_ram #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_push) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_res_ff.popped_payload, rsp_res_ff.popped_time};
   assign rsp_tuser  = {rsp_res_ff.queue_empty, rsp_res_ff.dropped, rsp_res_ff.popped_valid};

   // one item at a time: the block is busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while an item was in flight");

   // a response never reports both a popped event and a dropped insert
   a_pop_drop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("popped and dropped both set");

   // a dropped insert means the queue was full, so it cannot be empty
   a_drop_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> !rsp_tuser[2])
      else $error("dropped insert reported an empty queue");

   // without a popped event the event fields read as zero
   a_no_pop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("event fields nonzero without a popped event");

endmodule

### sim/tb_timestamp_ordered_event_queue_top.sv
// self-checking testbench for the timestamp ordered event queue
// depends on teq_pkg and timestamp_ordered_event_queue_top; stands alone otherwise

// keeps its own copy of the sorted event list and the expected responses
class event_order_scoreboard;
   teq_pkg::entry_type  stored_events[$];
   teq_pkg::result_type expected_results[$];
   int                  capacity;
   int unsigned         mismatch_count;

   function new(int depth);
      capacity       = depth;
      mismatch_count = 0;
   endfunction

   // work out the response of one accepted request and queue it
   function void note_request(logic op, logic [31:0] stamp, logic [31:0] payload);
      teq_pkg::result_type want;
      teq_pkg::entry_type  event_entry;
      int                  slot;
      want = '0;
      if (op == teq_pkg::OP_INSERT) begin
         if (stored_events.size() >= capacity) begin
            want.dropped = 1'b1;
         end else begin
            // behind every stored event with an equal or smaller timestamp
            slot = stored_events.size();
            for (int i = 0; i < stored_events.size(); i++) begin
               if (stamp < stored_events[i].time_stamp) begin
                  slot = i;
                  break;
               end
            end
            event_entry.time_stamp = stamp;
            event_entry.payload    = payload;
            stored_events.insert(slot, event_entry);
         end
      end else if (stored_events.size() > 0) begin
         event_entry         = stored_events.pop_front();
         want.popped_valid   = 1'b1;
         want.popped_time    = event_entry.time_stamp;
         want.popped_payload = event_entry.payload;
      end
      want.queue_empty = (stored_events.size() == 0);
      expected_results.insert(expected_results.size(), want);
   endfunction

   // compare one accepted response with the oldest expectation
   function void check_response(teq_pkg::result_type actual);
      teq_pkg::result_type want;
      if (expected_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR: unexpected response valid=%0b time=%h payload=%h drop=%0b empty=%0b",
                     actual.popped_valid, actual.popped_time, actual.popped_payload,
                     actual.dropped, actual.queue_empty);
         return;
      end
      want = expected_results.pop_front();
      if (actual.popped_valid !== want.popped_valid ||
          actual.popped_time !== want.popped_time ||
          actual.popped_payload !== want.popped_payload ||
          actual.dropped !== want.dropped ||
          actual.queue_empty !== want.queue_empty) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("ERROR: expected valid=%0b time=%h payload=%h drop=%0b empty=%0b",
                     want.popped_valid, want.popped_time, want.popped_payload,
                     want.dropped, want.queue_empty);
            $display("       actual   valid=%0b time=%h payload=%h drop=%0b empty=%0b",
                     actual.popped_valid, actual.popped_time, actual.popped_payload,
                     actual.dropped, actual.queue_empty);
         end
      end
   endfunction

   function int outstanding();
      return expected_results.size();
   endfunction
endclass

module tb_timestamp_ordered_event_queue_top;
   import teq_pkg::*;

   localparam int EVENT_CAPACITY = QUEUE_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS   = 650;
   // long enough for the worst-case insert, so this covers any trailing item
   localparam int SETTLE_CYCLES  = 4 * EVENT_CAPACITY + 20;
   localparam int HOLD_AT        = 120;
   localparam int HOLD_CYCLES    = 300;
   localparam int CYCLE_LIMIT    = 200000;

   typedef enum logic [1:0] {FILLING, DRAINING, MIXED} traffic_phase_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // [31:0] event_time, [63:32] event_payload
   logic [0:0]  req_tuser  = '0;   // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [31:0] popped_time, [63:32] popped_payload
   logic [2:0]  rsp_tuser;         // [0] popped_valid, [1] dropped, [2] queue_empty

   event_order_scoreboard board = new(EVENT_CAPACITY);
   int unsigned           cycle_count = 0;
   int unsigned           sent_count  = 0;
   bit                    sender_quiet = 1'b0;

   timestamp_ordered_event_queue_top #(
      .QUEUE_DEPTH(EVENT_CAPACITY)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // offer one request, wait for its transfer and hand it to the predictor
   task automatic send_request(input logic op, input logic [31:0] stamp,
                               input logic [31:0] payload);
      int unsigned gap;
      // every 40 items decide whether the next stretch runs without gaps
      if (sent_count % 40 == 0)
         sender_quiet = ($urandom_range(0, 2) == 0);
      gap = sender_quiet ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {payload, stamp};
      req_tuser  <= op;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      board.note_request(op, stamp, payload);
      sent_count++;
   endtask

   // timestamps: full range, small clustered values for ties, extremes,
   // and values close to the previous one
   function automatic logic [31:0] pick_stamp(logic [31:0] anchor);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5:       return $urandom_range(0, 15);
         6:          return anchor + $urandom_range(0, 3);
         7: begin
            case ($urandom_range(0, 3))
               0:       return 32'h0000_0000;
               1:       return 32'hffff_ffff;
               2:       return 32'h7fff_ffff;
               default: return 32'h8000_0000;
            endcase
         end
         default:    return anchor - $urandom_range(0, 3);
      endcase
   endfunction

   function automatic logic [31:0] pick_payload();
      case ($urandom_range(0, 15))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // response side: random stalls, quiet stretches and one long hold-off
   initial begin : response_side
      int unsigned         taken;
      int unsigned         hold;
      bit                  quiet;
      result_type          actual;
      taken = 0;
      quiet = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (taken % 40 == 0)
            quiet = ($urandom_range(0, 2) == 0);
         // long hold-off lets the queue back up and stall the request side
         if (taken == HOLD_AT)
            hold = HOLD_CYCLES;
         else
            hold = quiet ? 0 : $urandom_range(0, 9);
         repeat (hold) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         actual.popped_valid   = rsp_tuser[0];
         actual.dropped        = rsp_tuser[1];
         actual.queue_empty    = rsp_tuser[2];
         actual.popped_time    = rsp_tdata[31:0];
         actual.popped_payload = rsp_tdata[63:32];
         board.check_response(actual);
         taken++;
      end
   end

   // cycle limit guards against a hung handshake
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_timestamp_ordered_event_queue_top NOT OK");
      $finish;
   end

   initial begin : request_side
      logic [31:0]       fill_times[16];
      logic [31:0]       stamp;
      logic [31:0]       anchor;
      logic              op;
      traffic_phase_type phase;
      int unsigned       pct_insert;

      // sixteen inserts with extremes, ties and out-of-order stamps
      fill_times = '{32'd100, 32'h0000_0000, 32'hffff_ffff, 32'd100,
                     32'd100, 32'h8000_0000, 32'h7fff_ffff, 32'd1,
                     32'hffff_fffe, 32'hffff_ffff, 32'h0000_0000, 32'd50,
                     32'd200, 32'd150, 32'd100, 32'd3};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: pop on empty, fill up, insert into full, partial drain
      send_request(OP_POP, 32'hffff_ffff, 32'hffff_ffff);
      for (int i = 0; i < 16; i++)
         send_request(OP_INSERT, fill_times[i],
                      (i % 2 == 0) ? ~(32'h0101_0101 * i) : (32'h1111_0000 + i));
      send_request(OP_INSERT, 32'd5, 32'hdead_0005);
      repeat (5) send_request(OP_POP, $urandom, $urandom);

      // random: phases biased toward filling, draining or a balanced mix
      anchor     = 32'd100;
      phase      = MIXED;
      pct_insert = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 30 == 0) begin
            case ($urandom_range(0, 2))
               0:       begin phase = FILLING;  pct_insert = 80; end
               1:       begin phase = DRAINING; pct_insert = 20; end
               default: begin phase = MIXED;    pct_insert = 50; end
            endcase
         end
         op    = ($urandom_range(0, 99) < pct_insert) ? OP_INSERT : OP_POP;
         stamp = pick_stamp(anchor);
         if (op == OP_INSERT)
            anchor = stamp;
         send_request(op, stamp, pick_payload());
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // wait for every expected response, then let any stray one show up
      while (board.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (board.mismatch_count == 0 && board.outstanding() == 0)
         $display("tb_timestamp_ordered_event_queue_top OK");
      else
         $display("tb_timestamp_ordered_event_queue_top NOT OK");
      $finish;
   end

endmodule
